FILE: rtl/nfp_pkg.sv
package nfp_pkg;

  localparam int unsigned MaxPointsDef  = 16;
  localparam int unsigned CoordBitsDef  = 16;

  localparam int unsigned IdxW     = 4;
  localparam int unsigned CntW     = 5;
  localparam int unsigned RankW    = 4;
  localparam int unsigned DistW    = 17;
  localparam int unsigned CoordW   = 16;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 5;
  localparam int unsigned MaxOut   = 16;

  localparam logic CmdLoad  = 1'b0;
  localparam logic CmdQuery = 1'b1;

  localparam logic [CfgIdxW-1:0] RegPointsInUse   = 1'b0;
  localparam logic [CfgIdxW-1:0] RegResultsNeeded = 1'b1;

  localparam logic [CntW-1:0] PointsInUseRst   = 5'd10;
  localparam logic [CntW-1:0] ResultsNeededRst = 5'd0;

  typedef enum logic [2:0] {
    StIdle,
    StRead,
    StDiff,
    StSquare,
    StInsert,
    StRootInit,
    StRoot,
    StEmit
  } state_e;

  typedef struct packed {
    logic load_we;
    logic q_start;
    logic rd_en;
    logic diff_en;
    logic sqr_en;
    logic ins_en;
    logic root_init;
    logic root_step;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_is_query;
    logic n_zero;
    logic idx_last;
    logic root_done;
    logic rank_last;
    logic out_free;
  } ctrl_sts_t;

endpackage

FILE: rtl/nfp_in_if.sv
interface nfp_in_if;
  import nfp_pkg::*;
  logic              valid;
  logic              ready;
  logic              cmd;
  logic [IdxW-1:0]   point_index;
  logic [CoordW-1:0] coord_x;
  logic [CoordW-1:0] coord_y;

  modport source (output valid, cmd, point_index, coord_x, coord_y, input ready);
  modport sink   (input valid, cmd, point_index, coord_x, coord_y, output ready);
endinterface

FILE: rtl/nfp_out_if.sv
interface nfp_out_if;
  import nfp_pkg::*;
  logic             valid;
  logic             ready;
  logic [RankW-1:0] rank;
  logic [IdxW-1:0]  point_id;
  logic [DistW-1:0] distance;
  logic             last;

  modport source (output valid, rank, point_id, distance, last, input ready);
  modport sink   (input valid, rank, point_id, distance, last, output ready);
endinterface

FILE: rtl/nfp_ram.sv
module nfp_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/nfp_ctrl.sv
module nfp_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  nfp_pkg::ctrl_sts_t sts_i,
  output nfp_pkg::ctrl_cmd_t cmd_o
);
  import nfp_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (!sts_i.in_is_query) begin
            cmd_o.load_we = 1'b1;
          end else if (!sts_i.n_zero) begin
            cmd_o.q_start = 1'b1;
            state_d       = StRead;
          end
        end
      end
      StRead: begin
        cmd_o.rd_en = 1'b1;
        state_d     = StDiff;
      end
      StDiff: begin
        cmd_o.diff_en = 1'b1;
        state_d       = StSquare;
      end
      StSquare: begin
        cmd_o.sqr_en = 1'b1;
        state_d      = StInsert;
      end
      StInsert: begin
        cmd_o.ins_en = 1'b1;
        state_d      = sts_i.idx_last ? StRootInit : StRead;
      end
      StRootInit: begin
        cmd_o.root_init = 1'b1;
        state_d         = StRoot;
      end
      StRoot: begin
        cmd_o.root_step = 1'b1;
        if (sts_i.root_done) begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        // hold until the output register is free
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = sts_i.rank_last ? StIdle : StRootInit;
        end
      end
      default: state_d = StIdle;
    endcase
  end

endmodule

FILE: rtl/nfp_datapath.sv
module nfp_datapath #(
  parameter int unsigned MaxPoints = nfp_pkg::MaxPointsDef,
  parameter int unsigned CoordBits = nfp_pkg::CoordBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [nfp_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [nfp_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_cmd_i,
  input  logic [nfp_pkg::IdxW-1:0]      in_point_index_i,
  input  logic [nfp_pkg::CoordW-1:0]    in_coord_x_i,
  input  logic [nfp_pkg::CoordW-1:0]    in_coord_y_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [nfp_pkg::RankW-1:0]     out_rank_o,
  output logic [nfp_pkg::IdxW-1:0]      out_point_id_o,
  output logic [nfp_pkg::DistW-1:0]     out_distance_o,
  output logic                          out_last_o,
  input  nfp_pkg::ctrl_cmd_t            cmd_i,
  output nfp_pkg::ctrl_sts_t            sts_o
);
  import nfp_pkg::*;

  localparam int unsigned C     = CoordBits;
  localparam int unsigned AW    = (MaxPoints > 1) ? $clog2(MaxPoints) : 1;
  localparam int unsigned LD    = (MaxPoints < MaxOut) ? MaxPoints : MaxOut;
  localparam int unsigned LIW   = (LD > 1) ? $clog2(LD) : 1;
  localparam int unsigned DW    = 2 * C + 1;
  localparam int unsigned RB    = C + 1;
  localparam int unsigned VW    = 2 * RB;
  localparam int unsigned RemW  = RB + 3;
  localparam int unsigned RcW   = $clog2(RB);
  localparam int unsigned XW    = (C > CoordW) ? C : CoordW;
  localparam int unsigned RW    = (RB > DistW) ? RB : DistW;

  // configuration registers
  logic [CntW-1:0] pin_q, rneed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pin_q   <= PointsInUseRst;
      rneed_q <= ResultsNeededRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegPointsInUse:   pin_q   <= cfg_data_i;
        RegResultsNeeded: rneed_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [CntW-1:0] n_eff, k_eff;
  assign n_eff = (pin_q > CntW'(LD)) ? CntW'(LD) : pin_q;
  assign k_eff = (rneed_q == '0 || rneed_q > n_eff) ? n_eff : rneed_q;

  // input coordinates, low CoordBits used
  logic [XW-1:0] x_ext, y_ext;
  logic [C-1:0]  cx_in, cy_in;
  assign x_ext = XW'(in_coord_x_i);
  assign y_ext = XW'(in_coord_y_i);
  assign cx_in = x_ext[C-1:0];
  assign cy_in = y_ext[C-1:0];

  // point table
  logic           idx_ok;
  logic [2*C-1:0] rdata;
  logic [IdxW-1:0] idx_q;

  assign idx_ok = (32'(in_point_index_i) < 32'(MaxPoints));

  nfp_ram #(
    .Width (2 * C),
    .Depth (MaxPoints)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load_we && idx_ok),
    .waddr_i (AW'(in_point_index_i)),
    .wdata_i ({cx_in, cy_in}),
    .re_i    (cmd_i.rd_en),
    .raddr_i (AW'(idx_q)),
    .rdata_o (rdata)
  );

  // distance pipeline
  logic [C-1:0]   cx_q, cy_q, dx_q, dy_q, rx, ry;
  logic [2*C-1:0] sx_q, sy_q;
  logic [DW-1:0]  dnew;

  assign rx   = rdata[2*C-1:C];
  assign ry   = rdata[C-1:0];
  assign dnew = DW'(sx_q) + DW'(sy_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.q_start) begin
      cx_q <= cx_in;
      cy_q <= cy_in;
    end
    if (cmd_i.diff_en) begin
      dx_q <= (rx >= cx_q) ? rx - cx_q : cx_q - rx;
      dy_q <= (ry >= cy_q) ? ry - cy_q : cy_q - ry;
    end
    if (cmd_i.sqr_en) begin
      sx_q <= dx_q * dx_q;
      sy_q <= dy_q * dy_q;
    end
  end

  // sorted list, ascending key, ties keep earlier index first
  logic [DW-1:0]   key_q [LD];
  logic [IdxW-1:0] id_q  [LD];
  logic [LD-1:0]   vld_q;
  logic [LD-1:0]   le;

  always_comb begin
    for (int j = 0; j < LD; j++) begin
      le[j] = vld_q[j] && (key_q[j] <= dnew);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (cmd_i.q_start) begin
      vld_q <= '0;
    end else if (cmd_i.ins_en) begin
      for (int j = 0; j < LD; j++) begin
        if (!le[j]) begin
          if (j == 0 || le[(j == 0) ? 0 : j - 1]) begin
            vld_q[j] <= 1'b1;
          end else begin
            vld_q[j] <= vld_q[(j == 0) ? 0 : j - 1];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ins_en) begin
      for (int j = 0; j < LD; j++) begin
        if (!le[j]) begin
          if (j == 0 || le[(j == 0) ? 0 : j - 1]) begin
            key_q[j] <= dnew;
            id_q[j]  <= idx_q;
          end else begin
            key_q[j] <= key_q[(j == 0) ? 0 : j - 1];
            id_q[j]  <= id_q[(j == 0) ? 0 : j - 1];
          end
        end
      end
    end
  end

  // counters
  logic [RankW-1:0] rank_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      rank_q <= '0;
    end else begin
      if (cmd_i.q_start) begin
        idx_q  <= '0;
        rank_q <= '0;
      end else begin
        if (cmd_i.ins_en) idx_q <= idx_q + 1'b1;
        if (cmd_i.out_load) rank_q <= rank_q + 1'b1;
      end
    end
  end

  // square root, two radicand bits per step
  logic [VW-1:0]   val_q;
  logic [RemW-1:0] rem_q, rem_sh, trial;
  logic [RB-1:0]   root_q;
  logic [RcW-1:0]  rcnt_q;

  assign rem_sh = {rem_q[RemW-3:0], val_q[VW-1:VW-2]};
  assign trial  = RemW'({root_q, 2'b01});

  always_ff @(posedge clk_i) begin
    if (cmd_i.root_init) begin
      val_q  <= VW'(key_q[rank_q[LIW-1:0]]);
      rem_q  <= '0;
      root_q <= '0;
      rcnt_q <= '0;
    end else if (cmd_i.root_step) begin
      val_q  <= val_q << 2;
      rcnt_q <= rcnt_q + 1'b1;
      if (rem_sh >= trial) begin
        rem_q  <= rem_sh - trial;
        root_q <= {root_q[RB-2:0], 1'b1};
      end else begin
        rem_q  <= rem_sh;
        root_q <= {root_q[RB-2:0], 1'b0};
      end
    end
  end

  // output register
  logic [RW-1:0] root_w;
  logic          rank_last;
  assign root_w    = RW'(root_q);
  assign rank_last = ({1'b0, rank_q} == k_eff - 1'b1);

  logic             out_valid_q;
  logic [RankW-1:0] out_rank_q;
  logic [IdxW-1:0]  out_id_q;
  logic [DistW-1:0] out_dist_q;
  logic             out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_rank_q <= rank_q;
      out_id_q   <= id_q[rank_q[LIW-1:0]];
      out_dist_q <= root_w[DistW-1:0];
      out_last_q <= rank_last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_rank_o     = out_rank_q;
  assign out_point_id_o = out_id_q;
  assign out_distance_o = out_dist_q;
  assign out_last_o     = out_last_q;

  assign sts_o.in_is_query = (in_cmd_i == CmdQuery);
  assign sts_o.n_zero      = (n_eff == '0);
  assign sts_o.idx_last    = ({1'b0, idx_q} == n_eff - 1'b1);
  assign sts_o.root_done   = (rcnt_q == RcW'(RB - 1));
  assign sts_o.rank_last   = rank_last;
  assign sts_o.out_free    = !out_valid_q || out_ready_i;

endmodule

FILE: rtl/nearest_feature_points_core.sv
// channel | dir | transaction
// in_i    | in  | cmd, point_index, coord_x, coord_y (load or query)
// out_o   | out | rank, point_id, distance, last (one per emitted point)
// cfg     | in  | cfg_we_i, cfg_idx_i, cfg_data_i (points_in_use, results_needed)
//
// A load writes one point to the table. In a query over n points emitting k
// results, each point passes read, difference, square and sorted insert;
// each result runs a bit-pair square root.
// Input is taken only between queries; a stalled output holds the sequencer.
// Reset clears configuration to defaults and the control state; the point
// table is undefined until loaded.
module nearest_feature_points_core #(
  parameter int unsigned MaxPoints = nfp_pkg::MaxPointsDef,
  parameter int unsigned CoordBits = nfp_pkg::CoordBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [nfp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [nfp_pkg::CfgDataW-1:0] cfg_data_i,
  nfp_in_if.sink                       in_i,
  nfp_out_if.source                    out_o
);
  import nfp_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  nfp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  nfp_datapath #(
    .MaxPoints (MaxPoints),
    .CoordBits (CoordBits)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .in_cmd_i         (in_i.cmd),
    .in_point_index_i (in_i.point_index),
    .in_coord_x_i     (in_i.coord_x),
    .in_coord_y_i     (in_i.coord_y),
    .out_valid_o      (out_o.valid),
    .out_ready_i      (out_o.ready),
    .out_rank_o       (out_o.rank),
    .out_point_id_o   (out_o.point_id),
    .out_distance_o   (out_o.distance),
    .out_last_o       (out_o.last),
    .cmd_i            (cmd),
    .sts_o            (sts)
  );

endmodule
